// ===== sv/jh2d_pkg.sv =====
// ----------------------------------------------------------------------------
// jh2d_pkg
// Shared types and constants of the 2D joint histogram accumulator.
// ----------------------------------------------------------------------------
package jh2d_pkg;

    // default sizes
    localparam int DEF_BINS_PER_AXIS = 64;
    localparam int DEF_SAMPLE_BITS   = 16;

    // fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int READ_IDX_W  = 6;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 96;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH_B = 2'd3;

    // item kinds carried on tuser
    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_MODIFY,
        ST_WRITE
    } state_t;

    // status of one axis bin mapper
    typedef struct packed {
        logic busy;
        logic ok;
    } map_status_t;

endpackage

// ===== sv/jh2d_ram.sv =====
// ----------------------------------------------------------------------------
// jh2d_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module jh2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/jh2d_bin_map.sv =====
// ----------------------------------------------------------------------------
// jh2d_bin_map
// Maps one sample onto a bin of its axis: range check, then a restoring
// divider producing floor((v-low)*BINS/(high-low)) one bit per cycle.
// ----------------------------------------------------------------------------
module jh2d_bin_map #(
    parameter int BINS_PER_AXIS = jh2d_pkg::DEF_BINS_PER_AXIS,
    parameter int SW            = jh2d_pkg::SAMPLE_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SW-1:0]              sample,
    input  logic [SW-1:0]              range_low,
    input  logic [SW-1:0]              range_high,
    output jh2d_pkg::map_status_t      status,
    output logic [(BINS_PER_AXIS > 1 ? $clog2(BINS_PER_AXIS) : 1)-1:0] bin
);

    localparam int QB  = (BINS_PER_AXIS > 1) ? $clog2(BINS_PER_AXIS) : 1;
    localparam int NW  = SW + $clog2(BINS_PER_AXIS + 1);
    localparam int SCW = (QB > 1) ? $clog2(QB) : 1;

    logic           busy_reg, busy_next;
    logic [SCW-1:0] step_reg, step_next;
    logic           ok_reg;
    logic           top_reg;
    logic           empty_reg;
    logic [SW-1:0]  div_reg;
    logic [SW-1:0]  rem_reg, rem_next;
    logic [QB-1:0]  quo_reg, quo_next;

    logic [NW-1:0]  num;
    logic [SW:0]    trial;
    logic           fits;

    // scaled numerator, only meaningful when the sample is in range
    assign num = NW'(sample - range_low) * NW'(BINS_PER_AXIS);

    // one restoring step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QB-1]};
        fits      = (trial >= {1'b0, div_reg});
        rem_next  = fits ? SW'(trial - {1'b0, div_reg}) : SW'(trial);
        quo_next  = QB'({quo_reg, fits});
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg == SCW'(QB - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // datapath: load on start, step while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ok_reg    <= (sample >= range_low) && (sample <= range_high);
            top_reg   <= (sample == range_high);
            empty_reg <= (range_high == range_low);
            div_reg   <= range_high - range_low;
            rem_reg   <= SW'(num >> QB);
            quo_reg   <= num[QB-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.ok   = ok_reg;

    // top value clamps to the last bin, an empty range maps to bin 0
    assign bin = empty_reg ? '0 : (top_reg ? QB'(BINS_PER_AXIS - 1) : quo_reg);

endmodule

// ===== sv/joint_histogram_2d_accumulator.sv =====
// ----------------------------------------------------------------------------
// joint_histogram_2d_accumulator
// 2D joint histogram: bins sample pairs, reads and clears bins.
// ----------------------------------------------------------------------------
// Sequence: an accumulate word passes the divider steps, RAM read, modify and
//   write before it reaches the output register; a readout skips the divider,
//   and a rejected pair skips the RAM access.
// Throughput: one word at a time; next word taken in the cycle after the
//   result is registered; set by bit-serial divider, RAM and output stalls.
// Reset: counters and config return to defaults, then a clearing pass
//   zeroes all BINS*BINS bin RAM words before the first word is accepted.
module joint_histogram_2d_accumulator #(
    parameter int BINS_PER_AXIS = jh2d_pkg::DEF_BINS_PER_AXIS,
    parameter int SAMPLE_BITS   = jh2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jh2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jh2d_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_a[15:0], sample_b[31:16], read_x[37:32], read_y[43:38], zero pad
    input  logic [jh2d_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic                                s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bin_count[31:0], peak_count[63:32], overflow_count[95:64]
    output logic [jh2d_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // out_of_range[0]
    output logic                                m_axis_tuser
);

    localparam int SW    = (SAMPLE_BITS < jh2d_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : jh2d_pkg::SAMPLE_W;
    localparam int QB    = (BINS_PER_AXIS > 1) ? $clog2(BINS_PER_AXIS) : 1;
    localparam int DEPTH = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = jh2d_pkg::COUNT_W;

    jh2d_pkg::state_t state_reg, state_next;

    // config registers
    logic [jh2d_pkg::CFG_DATA_W-1:0] low_a_reg, high_a_reg, low_b_reg, high_b_reg;

    // item context
    logic          func_reg, func_next;
    logic          reject_reg, reject_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] wdata_reg, wdata_next;

    // running counters
    logic [CW-1:0] peak_reg, peak_next;
    logic [CW-1:0] ovf_reg, ovf_next;

    // clearing pass
    logic [AW-1:0] clr_reg, clr_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic [jh2d_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic                               out_flag_reg;
    logic                               out_load;

    // handshake and fields
    logic                               in_accept;
    logic [jh2d_pkg::SAMPLE_W-1:0]      sample_a, sample_b;
    logic [jh2d_pkg::READ_IDX_W-1:0]    read_x, read_y;
    logic                               in_grid;
    logic                               map_start;

    // bin mappers
    jh2d_pkg::map_status_t map_a, map_b;
    logic [QB-1:0]         bin_a, bin_b;

    // RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata, ram_rdata;

    assign sample_a = s_axis_tdata[15:0];
    assign sample_b = s_axis_tdata[31:16];
    assign read_x   = s_axis_tdata[37:32];
    assign read_y   = s_axis_tdata[43:38];
    assign in_grid  = (32'(read_x) < 32'(BINS_PER_AXIS))
                   && (32'(read_y) < 32'(BINS_PER_AXIS));

    assign s_axis_tready = (state_reg == jh2d_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign map_start     = in_accept && (s_axis_tuser == jh2d_pkg::FUNC_ACCUM);
    assign cfg_ready     = 1'b1;

    // axis mappers, both run in lockstep
    jh2d_bin_map #(
        .BINS_PER_AXIS (BINS_PER_AXIS),
        .SW            (SW)
    ) u_map_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (map_start),
        .sample     (sample_a[SW-1:0]),
        .range_low  (low_a_reg[SW-1:0]),
        .range_high (high_a_reg[SW-1:0]),
        .status     (map_a),
        .bin        (bin_a)
    );

    jh2d_bin_map #(
        .BINS_PER_AXIS (BINS_PER_AXIS),
        .SW            (SW)
    ) u_map_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (map_start),
        .sample     (sample_b[SW-1:0]),
        .range_low  (low_b_reg[SW-1:0]),
        .range_high (high_b_reg[SW-1:0]),
        .status     (map_b),
        .bin        (bin_b)
    );

    // bin store
    jh2d_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_a_reg  <= '0;
            high_a_reg <= '1;
            low_b_reg  <= '0;
            high_b_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jh2d_pkg::REG_RANGE_LOW_A:  low_a_reg  <= cfg_data;
                jh2d_pkg::REG_RANGE_HIGH_A: high_a_reg <= cfg_data;
                jh2d_pkg::REG_RANGE_LOW_B:  low_b_reg  <= cfg_data;
                jh2d_pkg::REG_RANGE_HIGH_B: high_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: next state, RAM control, counters
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        reject_next    = reject_reg;
        wr_pend_next   = wr_pend_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        wdata_next     = wdata_reg;
        peak_next      = peak_reg;
        ovf_next       = ovf_reg;
        clr_next       = clr_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = wdata_reg;
        ram_re         = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            jh2d_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = jh2d_pkg::ST_IDLE;
                end
            end

            jh2d_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next    = s_axis_tuser;
                    reject_next  = 1'b0;
                    wr_pend_next = 1'b0;
                    count_next   = '0;
                    if (s_axis_tuser == jh2d_pkg::FUNC_ACCUM)
                    begin
                        state_next = jh2d_pkg::ST_MAP;
                    end
                    else if (in_grid)
                    begin
                        addr_next  = AW'(read_x) + AW'(read_y) * AW'(BINS_PER_AXIS);
                        state_next = jh2d_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = jh2d_pkg::ST_WRITE;
                    end
                end
            end

            jh2d_pkg::ST_MAP:
            begin
                if (!map_a.busy)
                begin
                    if (map_a.ok && map_b.ok)
                    begin
                        addr_next  = AW'(bin_a) + AW'(bin_b) * AW'(BINS_PER_AXIS);
                        state_next = jh2d_pkg::ST_READ;
                    end
                    else
                    begin
                        reject_next = 1'b1;
                        state_next  = jh2d_pkg::ST_WRITE;
                    end
                end
            end

            jh2d_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = jh2d_pkg::ST_MODIFY;
            end

            jh2d_pkg::ST_MODIFY:
            begin
                wr_pend_next = 1'b1;
                if (func_reg == jh2d_pkg::FUNC_ACCUM)
                begin
                    count_next = (ram_rdata == jh2d_pkg::COUNT_MAX) ? ram_rdata
                                                                    : ram_rdata + 1'b1;
                    wdata_next = count_next;
                end
                else
                begin
                    count_next = ram_rdata;
                    wdata_next = '0;
                end
                state_next = jh2d_pkg::ST_WRITE;
            end

            jh2d_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    ram_we   = wr_pend_reg;
                    out_load = 1'b1;
                    if (reject_reg)
                    begin
                        if (ovf_reg != jh2d_pkg::COUNT_MAX)
                        begin
                            ovf_next = ovf_reg + 1'b1;
                        end
                    end
                    else if ((func_reg == jh2d_pkg::FUNC_ACCUM) && (count_reg > peak_reg))
                    begin
                        peak_next = count_reg;
                    end
                    state_next = jh2d_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = jh2d_pkg::ST_IDLE;
            end
        endcase

        // output valid
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jh2d_pkg::ST_CLEAR;
            clr_reg       <= '0;
            peak_reg      <= '0;
            ovf_reg       <= '0;
            out_valid_reg <= 1'b0;
            func_reg      <= jh2d_pkg::FUNC_ACCUM;
            reject_reg    <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            peak_reg      <= peak_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            func_reg      <= func_next;
            reject_reg    <= reject_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        count_reg <= count_next;
        wdata_reg <= wdata_next;
        if (out_load)
        begin
            out_data_reg <= {ovf_next, peak_next, count_reg};
            out_flag_reg <= reject_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

endmodule

// ===== sv/jh2d_checker.sv =====
// ----------------------------------------------------------------------------
// jh2d_checker
// Port-level assertions for the joint histogram accumulator.
// ----------------------------------------------------------------------------
module jh2d_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [jh2d_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    // a rejected pair reports a zero bin count
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("rejected pair with nonzero bin count");

    // no bin ever exceeds the peak
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:0] <= m_axis_tdata[63:32]))
        else $error("bin count above peak");

    // one word in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");

endmodule

bind joint_histogram_2d_accumulator jh2d_checker u_jh2d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
